// File: rtl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package utf8sd_pkg;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [7:0]      CONT_MASK      = 8'hC0;
   localparam logic [7:0]      CONT_TAG       = 8'h80;
   localparam logic [7:0]      SIX_BIT_MASK   = 8'h3F;

   // One input item: a raw byte and its end-of-string mark.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_text;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            last_of_run;
   } rsp_type;

   // Everything one byte produces: a run of replacements, then an optional tail.
   typedef struct packed {
      logic [1:0]      bad_count;
      logic            tail_valid;
      logic [CP_W-1:0] tail_value;
      logic            tail_malformed;
   } burst_type;

endpackage

`default_nettype wire

// File: rtl/utf8sd_decode.sv
// Sequence state and single-pass byte decoder.
// Depends on utf8sd_pkg; feeds utf8sd_emit with one burst descriptor per byte.
`default_nettype none

module utf8sd_decode
   import utf8sd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire req_type   in_data,
   output burst_type      burst
);

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      rem_ff, rem_in;
   logic [1:0]      taken_ff, taken_in;

   logic [7:0]      b;
   logic            eot;
   logic            is_cont;
   logic            lead_one, lead_open, lead_starts;
   logic [1:0]      lead_rem;
   logic [CP_W-1:0] lead_bits;
   logic [CP_W-1:0] shifted;
   logic [1:0]      rem_dec, taken_inc;
   logic [1:0]      flush_cur, flush_inc;

   assign b       = in_data.byte_in;
   assign eot     = in_data.end_of_text;
   assign is_cont = (b & CONT_MASK) == CONT_TAG;

   // Lead byte classification
   always_comb begin
      lead_one  = 1'b0;
      lead_open = 1'b0;
      lead_rem  = 2'd0;
      lead_bits = '0;
      case (b) inside
         8'b0???????: lead_one = 1'b1;
         8'b110?????: begin
            lead_open = 1'b1;
            lead_rem  = 2'd1;
            lead_bits = {16'd0, b[4:0]};
         end
         8'b1110????: begin
            lead_open = 1'b1;
            lead_rem  = 2'd2;
            lead_bits = {17'd0, b[3:0]};
         end
         8'b11110???: begin
            lead_open = 1'b1;
            lead_rem  = 2'd3;
            lead_bits = {18'd0, b[2:0]};
         end
         default: lead_one = 1'b0;
      endcase
   end

   // multi-byte lead marked as end of text cannot open anything
   assign lead_starts = lead_open && !eot;

   assign shifted   = {partial_ff[CP_W-7:0], b[5:0] & SIX_BIT_MASK[5:0]};
   assign rem_dec   = rem_ff - 2'd1;
   assign taken_inc = taken_ff + 2'd1;
   // one replacement for the lead plus one per continuation, at most three
   assign flush_cur = (taken_ff == 2'd3)  ? 2'd3 : taken_ff + 2'd1;
   assign flush_inc = (taken_inc == 2'd3) ? 2'd3 : taken_inc + 2'd1;

   always_comb begin
      burst      = '0;
      partial_in = partial_ff;
      rem_in     = rem_ff;
      taken_in   = taken_ff;
      if (rem_ff != 2'd0 && is_cont) begin
         if (rem_dec == 2'd0) begin
            burst.tail_valid = 1'b1;
            burst.tail_value = shifted;
            partial_in       = '0;
            rem_in           = 2'd0;
            taken_in         = 2'd0;
         end else if (eot) begin
            burst.bad_count = flush_inc;
            partial_in      = '0;
            rem_in          = 2'd0;
            taken_in        = 2'd0;
         end else begin
            partial_in = shifted;
            rem_in     = rem_dec;
            taken_in   = taken_inc;
         end
      end else begin
         // idle, or an open sequence broken by this byte: decode it as a lead
         burst.bad_count      = (rem_ff != 2'd0) ? flush_cur : 2'd0;
         burst.tail_valid     = !lead_starts;
         burst.tail_value     = lead_one ? {13'd0, b} : REPLACEMENT_CP;
         burst.tail_malformed = !lead_one;
         partial_in           = lead_starts ? lead_bits : '0;
         rem_in               = lead_starts ? lead_rem : 2'd0;
         taken_in             = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         rem_ff     <= 2'd0;
         taken_ff   <= 2'd0;
      end else if (advance) begin
         partial_ff <= partial_in;
         rem_ff     <= rem_in;
         taken_ff   <= taken_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/utf8sd_emit.sv
// Result register: holds one burst and hands its results out one a cycle while rsp_ready is high.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_emit
   import utf8sd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire burst_type burst,
   output logic           free,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   logic [1:0]      bad_left_ff;
   logic            tail_pend_ff;
   logic [CP_W-1:0] tail_value_ff;
   logic            tail_mal_ff;
   logic            last;

   assign rsp_valid = (bad_left_ff != 2'd0) || tail_pend_ff;
   assign last      = (bad_left_ff == 2'd0) || (bad_left_ff == 2'd1 && !tail_pend_ff);
   assign free      = !rsp_valid || (rsp_ready && last);

   assign rsp_data.code_point  = (bad_left_ff != 2'd0) ? REPLACEMENT_CP : tail_value_ff;
   assign rsp_data.malformed   = (bad_left_ff != 2'd0) ? 1'b1 : tail_mal_ff;
   assign rsp_data.last_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_left_ff  <= 2'd0;
         tail_pend_ff <= 1'b0;
      end else if (load) begin
         bad_left_ff  <= burst.bad_count;
         tail_pend_ff <= burst.tail_valid;
      end else if (rsp_valid && rsp_ready) begin
         if (bad_left_ff != 2'd0) begin
            bad_left_ff <= bad_left_ff - 2'd1;
         end else begin
            tail_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tail_value_ff <= burst.tail_value;
         tail_mal_ff   <= burst.tail_malformed;
      end
   end

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input register, decoder, result register.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_emit.
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+-----------------------------
//   req     | in        | req_valid, req_ready, req_data | byte_in, end_of_text
//   rsp     | out       | rsp_valid, rsp_ready, rsp_data | code_point, malformed,
//           |           |                                | last_of_run
//
// One byte per cycle sustained while rsp_ready is high and no byte gives more
// than one result. A byte is held in the input register, is decoded in a single
// pass against the sequence state and lands in the result register, which shows
// its first result. A byte gives 0 to 4 results and the result register hands out
// one a cycle while rsp_ready is high, so a malformed burst holds the decoder until its last result is taken.
// Synchronous reset clears the sequence state and both valid flags.
// A stalled rsp side fills the input register, then drops req_ready.
`default_nettype none

module utf8_stream_decoder_unit
   import utf8sd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      emit_free;
   logic      advance;
   burst_type burst;

   // the held byte moves on once the result register can take its burst
   assign advance   = in_valid_ff && emit_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   utf8sd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_data (in_data_ff),
      .burst   (burst)
   );

   // an absorbed continuation byte has an empty burst; loading it is harmless
   utf8sd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .burst     (burst),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/utf8sd_checker.sv
// Port-level checks for utf8_stream_decoder_unit, bound to the top level.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_checker
   import utf8sd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // a good code point always closes its run
   a_good_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.malformed |-> rsp_data.last_of_run)
      else $error("well-formed result not last of run");

   // items before the last of a run are replacements
   a_leading_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |->
         rsp_data.malformed && rsp_data.code_point == REPLACEMENT_CP)
      else $error("non-final result is not a replacement");

   // reset leaves the block empty and ready
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_checker (.*);

`default_nettype wire
